// ===== hw/rtl/kda_pkg.sv =====
// Shared types and constants for the key debounce and auto-repeat block.
package kda_pkg;

    localparam int unsigned KEYS     = 4;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_STEP = 1'd1;

    localparam logic [CFG_W-1:0] HOLD_TICKS_RST  = 8'd50;
    localparam logic [CFG_W-1:0] REPEAT_STEP_RST = 8'd10;
    localparam logic [KEYS-1:0]  KEYS_ALL        = 4'hF;

    typedef logic [KEYS-1:0]  key_vec_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Scan state carried from one tick to the next
    typedef struct packed {
        key_vec_t prev_sample;
        key_vec_t press_mask;
        key_vec_t repeat_mask;
        cnt_t     hold_count;
    } scan_state_t;

    localparam scan_state_t SCAN_STATE_RST = '{
        prev_sample: '0,
        press_mask:  KEYS_ALL,
        repeat_mask: KEYS_ALL,
        hold_count:  '0
    };

endpackage

// ===== hw/rtl/kda_step.sv =====
// One scan tick: debounce, new-press detect and auto-repeat counter update.
module kda_step
(
    input  kda_pkg::scan_state_t cur,
    input  kda_pkg::key_vec_t    pin_levels,
    input  kda_pkg::cnt_t        hold_ticks,
    input  kda_pkg::cnt_t        repeat_step,
    output kda_pkg::scan_state_t nxt,
    output kda_pkg::key_vec_t    key_events
);

    kda_pkg::key_vec_t sample;
    kda_pkg::key_vec_t held;
    kda_pkg::key_vec_t pmask;
    kda_pkg::key_vec_t rmask;
    kda_pkg::cnt_t     hcount;

    always_comb
    begin
        sample = ~pin_levels;
        held   = sample & cur.prev_sample;
        pmask  = cur.press_mask | ~held;
        rmask  = cur.repeat_mask | ~held;
        hcount = cur.hold_count;

        // any new press restarts the hold timer and re-arms repeat set
        if ((pmask & held) != '0)
        begin
            hcount = '0;
            rmask  = pmask;
        end

        nxt.prev_sample = sample;
        nxt.repeat_mask = rmask;

        if (hcount >= hold_ticks)
        begin
            key_events     = held & rmask;
            // clamp at zero
            nxt.hold_count = (hcount > repeat_step) ? (hcount - repeat_step) : '0;
        end
        else
        begin
            key_events     = held & pmask;
            nxt.hold_count = hcount + kda_pkg::cnt_t'(1);
        end

        nxt.press_mask = pmask & ~key_events;
    end

endmodule

// ===== hw/rtl/key_debounce_autorepeat_top.sv =====
// Pipeline: an accepted input is held in the input register; its result is held in the output register.
// Throughput: one scan tick per clock while the sink does not stall; input register feeds the update logic,
// whose result lands in an output register that the sink may stall.
// The input stage can take a new item while the output stalls, so a stall holds at most one item in each.
// Reset (rst_n low, async): pipeline empty, hold_ticks=50, repeat_step=10,
// no key pressed, press and repeat masks all ones, hold counter zero.
module key_debounce_autorepeat_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kda_pkg::TDATA_W-1:0]   s_tdata,   // [3:0] pin_levels, [7:4] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kda_pkg::TDATA_W-1:0]   m_tdata,   // [3:0] key_events, [7:4] zero
    input  logic                          cfg_we,
    input  logic [kda_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kda_pkg::CFG_W-1:0]     cfg_wdata
);

    logic                  in_valid_reg;
    kda_pkg::key_vec_t     in_pins_reg;
    logic                  out_valid_reg;
    kda_pkg::key_vec_t     out_events_reg;
    kda_pkg::cnt_t         hold_ticks_reg;
    kda_pkg::cnt_t         repeat_step_reg;
    kda_pkg::scan_state_t  state_reg;
    kda_pkg::scan_state_t  state_next;
    kda_pkg::key_vec_t     events_next;
    logic                  out_free;
    logic                  advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    kda_step u_step
    (
        .cur         (state_reg),
        .pin_levels  (in_pins_reg),
        .hold_ticks  (hold_ticks_reg),
        .repeat_step (repeat_step_reg),
        .nxt         (state_next),
        .key_events  (events_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg  <= kda_pkg::HOLD_TICKS_RST;
            repeat_step_reg <= kda_pkg::REPEAT_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kda_pkg::REG_HOLD_TICKS:  hold_ticks_reg  <= cfg_wdata;
                kda_pkg::REG_REPEAT_STEP: repeat_step_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= kda_pkg::SCAN_STATE_RST;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_pins_reg <= s_tdata[kda_pkg::KEYS-1:0];
        if (advance)
            out_events_reg <= events_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(kda_pkg::TDATA_W-kda_pkg::KEYS){1'b0}}, out_events_reg};

endmodule

// ===== hw/rtl/kda_checker.sv =====
// Port-level checks for the key debounce block, bound to its top level.
module kda_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [kda_pkg::TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:4] == 4'h0)
        else $error("result padding not zero");

    // a free output side never blocks a request
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with output free");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
        else $error("accepted request did not reach output");

endmodule

bind key_debounce_autorepeat_top kda_checker u_kda_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
